### rtl/smr_pkg.sv
// shared types and constants for the staged interval remap block
package smr_pkg;

    localparam int VALUE_BITS  = 48;
    localparam int DEF_STAGES  = 7;
    localparam int DEF_ENTRIES = 64;

    typedef logic [VALUE_BITS-1:0] value_t;

    typedef struct packed {
        value_t dest;
        value_t src;
        value_t len;
    } entry_t;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_COUNT = 2'd1,
        CMD_MAP   = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } scan_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } scan_status_t;

endpackage

### rtl/smr_table.sv
// entry memory: one write port, one registered read port
module smr_table #(
    parameter int DEPTH  = smr_pkg::DEF_STAGES * smr_pkg::DEF_ENTRIES,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  smr_pkg::entry_t     wr_data,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output smr_pkg::entry_t     rd_data
);
    import smr_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/smr_scan.sv
// stage sequencer: walks each stage's entries through the table read port
module smr_scan #(
    parameter int STAGES  = smr_pkg::DEF_STAGES,
    parameter int ENTRIES = smr_pkg::DEF_ENTRIES,
    parameter int ADDR_W  = (STAGES * ENTRIES > 1) ? $clog2(STAGES * ENTRIES) : 1,
    parameter int STG_W   = (STAGES > 1) ? $clog2(STAGES) : 1,
    parameter int CNT_W   = $clog2(ENTRIES + 1)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  smr_pkg::value_t         query,
    input  logic                    cnt_wr_en,
    input  logic [STG_W-1:0]        cnt_wr_stage,
    input  logic [CNT_W-1:0]        cnt_wr_value,
    output logic                    rd_en,
    output logic [ADDR_W-1:0]       rd_addr,
    input  smr_pkg::entry_t         rd_data,
    input  logic                    result_take,
    output smr_pkg::value_t         result,
    output smr_pkg::scan_status_t   status
);
    import smr_pkg::*;

    scan_state_t       state_reg, state_next;
    logic [STG_W-1:0]  stage_reg;
    logic [ADDR_W-1:0] base_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  counts_reg [STAGES];
    logic              p1_valid_reg, p2_valid_reg;
    value_t            value_reg;
    value_t            diff_reg, len_reg, dest_reg;
    logic              ge_reg;

    logic              in_scan;
    logic              hit;
    logic              issue;
    logic              stage_end;
    logic              last_stage;
    logic [CNT_W-1:0]  cur_count;
    value_t            new_value;

    assign in_scan    = (state_reg == ST_SCAN);
    assign cur_count  = counts_reg[stage_reg];
    assign hit        = p2_valid_reg && ge_reg && (diff_reg < len_reg);
    assign issue      = in_scan && (idx_reg < cur_count) && !hit;
    assign stage_end  = in_scan && (hit || ((idx_reg >= cur_count)
                        && !p1_valid_reg && !p2_valid_reg));
    assign last_stage = (stage_reg == STG_W'(STAGES - 1));
    assign new_value  = hit ? (dest_reg + diff_reg) : value_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stage_end && last_stage)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (result_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        status.busy = 1'b1;
        status.done = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                status.busy = 1'b0;
            end
            ST_DONE:
            begin
                status.done = 1'b1;
            end
            default:
            begin
                status.busy = 1'b1;
            end
        endcase
    end

    assign rd_en   = issue;
    assign rd_addr = base_reg + ADDR_W'(idx_reg);
    assign result  = value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            stage_reg    <= '0;
            base_reg     <= '0;
            idx_reg      <= '0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            for (int i = 0; i < STAGES; i++)
            begin
                counts_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cnt_wr_en)
            begin
                counts_reg[cnt_wr_stage] <= cnt_wr_value;
            end
            if (state_reg == ST_IDLE)
            begin
                stage_reg    <= '0;
                base_reg     <= '0;
                idx_reg      <= '0;
                p1_valid_reg <= 1'b0;
                p2_valid_reg <= 1'b0;
            end
            else if (stage_end)
            begin
                idx_reg      <= '0;
                p1_valid_reg <= 1'b0;
                p2_valid_reg <= 1'b0;
                if (!last_stage)
                begin
                    stage_reg <= stage_reg + 1'b1;
                    base_reg  <= base_reg + ADDR_W'(ENTRIES);
                end
            end
            else if (in_scan)
            begin
                p1_valid_reg <= issue;
                p2_valid_reg <= p1_valid_reg;
                if (issue)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
        end
    end

    // entry compare pipeline
    always_ff @(posedge clk)
    begin
        diff_reg <= value_reg - rd_data.src;
        ge_reg   <= (value_reg >= rd_data.src);
        len_reg  <= rd_data.len;
        dest_reg <= rd_data.dest;
        if ((state_reg == ST_IDLE) && start)
        begin
            value_reg <= query;
        end
        else if (stage_end)
        begin
            value_reg <= new_value;
        end
    end

endmodule

### rtl/staged_interval_remap_min_top.sv
// top level of the staged interval remap block with running minimum
// write, count and clear transactions return nothing
// a map transaction walks the stages in order, reading up to count entries in each, one
// table entry read per cycle; a stage ends early on its first matching entry
// new transactions are stalled while a map runs; the result sits in an output register
// reset clears stage counts to zero and the minimum to all ones; table entries are not reset
module staged_interval_remap_min_top #(
    parameter int STAGES  = smr_pkg::DEF_STAGES,
    parameter int ENTRIES = smr_pkg::DEF_ENTRIES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [2:0]  stage_number,
    input  logic [5:0]  entry_slot,
    input  logic [47:0] dest_start,
    input  logic [47:0] source_start,
    input  logic [47:0] span_length,
    input  logic [6:0]  used_entries,
    input  logic [47:0] query_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [47:0] mapped_value,
    output logic [47:0] lowest_so_far
);
    import smr_pkg::*;

    localparam int DEPTH  = STAGES * ENTRIES;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int STG_W  = (STAGES > 1) ? $clog2(STAGES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);

    cmd_t              cmd;
    logic              accept;
    logic              stage_ok;
    logic              slot_ok;
    logic              tbl_wr_en;
    logic [ADDR_W-1:0] tbl_wr_addr;
    entry_t            tbl_wr_data;
    logic              tbl_rd_en;
    logic [ADDR_W-1:0] tbl_rd_addr;
    entry_t            tbl_rd_data;
    logic              cnt_wr_en;
    logic [CNT_W-1:0]  cnt_wr_value;
    logic              map_start;
    logic              clear_min;
    logic              take;
    value_t            scan_result;
    value_t            new_min;
    scan_status_t      scan_status;

    logic              out_valid_reg, out_valid_next;
    value_t            min_reg;
    value_t            mapped_reg;
    value_t            lowest_reg;

    assign cmd      = cmd_t'(command);
    assign in_stall = scan_status.busy;
    assign accept   = in_valid && !in_stall;
    assign stage_ok = (int'(stage_number) < STAGES);
    assign slot_ok  = (int'(entry_slot) < ENTRIES);

    always_comb
    begin
        tbl_wr_en = 1'b0;
        cnt_wr_en = 1'b0;
        map_start = 1'b0;
        clear_min = 1'b0;
        case (cmd)
            CMD_WRITE: tbl_wr_en = accept && stage_ok && slot_ok;
            CMD_COUNT: cnt_wr_en = accept && stage_ok;
            CMD_MAP:   map_start = accept;
            CMD_CLEAR: clear_min = accept;
            default:   map_start = 1'b0;
        endcase
    end

    assign tbl_wr_addr  = ADDR_W'(int'(stage_number) * ENTRIES + int'(entry_slot));
    assign tbl_wr_data  = '{dest: dest_start, src: source_start, len: span_length};
    assign cnt_wr_value = (int'(used_entries) > ENTRIES) ? CNT_W'(ENTRIES)
                                                         : CNT_W'(used_entries);

    smr_table #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    smr_scan #(
        .STAGES  (STAGES),
        .ENTRIES (ENTRIES),
        .ADDR_W  (ADDR_W),
        .STG_W   (STG_W),
        .CNT_W   (CNT_W)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (map_start),
        .query        (query_value),
        .cnt_wr_en    (cnt_wr_en),
        .cnt_wr_stage (STG_W'(stage_number)),
        .cnt_wr_value (cnt_wr_value),
        .rd_en        (tbl_rd_en),
        .rd_addr      (tbl_rd_addr),
        .rd_data      (tbl_rd_data),
        .result_take  (take),
        .result       (scan_result),
        .status       (scan_status)
    );

    assign take    = scan_status.done && (!out_valid_reg || !out_stall);
    assign new_min = (scan_result < min_reg) ? scan_result : min_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            min_reg       <= '1;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (clear_min)
            begin
                min_reg <= '1;
            end
            else if (take)
            begin
                min_reg <= new_min;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            mapped_reg <= scan_result;
            lowest_reg <= new_min;
        end
    end

    assign out_valid     = out_valid_reg;
    assign mapped_value  = mapped_reg;
    assign lowest_so_far = lowest_reg;

endmodule

### tb/testbench.sv
// testbench for the staged interval remap block: scoreboard class, stimulus tasks, checks
`timescale 1ns / 100ps

module testbench;

    import smr_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int RANDOM_ITEMS = 450;
    localparam int SETTLE_CYCLES = 500;

    typedef struct {
        value_t mapped;
        value_t lowest;
    } map_result_t;

    class remap_checker;
        value_t dest_tab [DEF_STAGES][DEF_ENTRIES];
        value_t src_tab [DEF_STAGES][DEF_ENTRIES];
        value_t len_tab [DEF_STAGES][DEF_ENTRIES];
        int unsigned stage_cnt [DEF_STAGES];
        value_t lowest;
        map_result_t expected_maps [$];
        int unsigned failures;
        int unsigned checked;

        function new();
            foreach (stage_cnt[i])
                stage_cnt[i] = 0;
            lowest = '1;
            failures = 0;
            checked = 0;
        endfunction

        function value_t remap_stage(int st, value_t v);
            for (int k = 0; k < stage_cnt[st]; k++)
            begin
                if (v >= src_tab[st][k] && (v - src_tab[st][k]) < len_tab[st][k])
                    return dest_tab[st][k] + (v - src_tab[st][k]);
            end
            return v;
        endfunction

        function void note_transaction(cmd_t cmd, logic [2:0] stage, logic [5:0] slot,
                                       value_t d, value_t s, value_t l,
                                       logic [6:0] used, value_t q);
            value_t v;
            map_result_t r;
            case (cmd)
                CMD_WRITE:
                begin
                    if (stage < DEF_STAGES && slot < DEF_ENTRIES)
                    begin
                        dest_tab[stage][slot] = d;
                        src_tab[stage][slot] = s;
                        len_tab[stage][slot] = l;
                    end
                end
                CMD_COUNT:
                begin
                    if (stage < DEF_STAGES)
                        stage_cnt[stage] = (used > DEF_ENTRIES) ? DEF_ENTRIES : used;
                end
                CMD_CLEAR:
                    lowest = '1;
                default:
                begin
                    v = q;
                    for (int st = 0; st < DEF_STAGES; st++)
                        v = remap_stage(st, v);
                    if (v < lowest)
                        lowest = v;
                    r.mapped = v;
                    r.lowest = lowest;
                    expected_maps.push_back(r);
                end
            endcase
        endfunction

        function void check_result(value_t mapped, value_t low);
            map_result_t r;
            if (expected_maps.size() == 0)
            begin
                $error("unexpected result: mapped_value %h lowest_so_far %h", mapped, low);
                failures++;
                return;
            end
            r = expected_maps.pop_front();
            checked++;
            if (mapped !== r.mapped)
            begin
                $error("mapped_value: expected %h, actual %h", r.mapped, mapped);
                failures++;
            end
            if (low !== r.lowest)
            begin
                $error("lowest_so_far: expected %h, actual %h", r.lowest, low);
                failures++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  command = CMD_MAP;
    logic [2:0]  stage_number = '0;
    logic [5:0]  entry_slot = '0;
    logic [47:0] dest_start = '0;
    logic [47:0] source_start = '0;
    logic [47:0] span_length = '0;
    logic [6:0]  used_entries = '0;
    logic [47:0] query_value = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [47:0] mapped_value;
    logic [47:0] lowest_so_far;

    remap_checker tracker = new();
    bit slot_written [DEF_STAGES][DEF_ENTRIES];
    value_t probe_points [$];
    bit quiet = 1'b0;
    int unsigned effective = 0;
    int unsigned full_loads = 0;
    int unsigned clears = 0;
    longint unsigned cycles = 0;

    staged_interval_remap_min_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .stage_number (stage_number),
        .entry_slot   (entry_slot),
        .dest_start   (dest_start),
        .source_start (source_start),
        .span_length  (span_length),
        .used_entries (used_entries),
        .query_value  (query_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .mapped_value (mapped_value),
        .lowest_so_far(lowest_so_far)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_result(mapped_value, lowest_so_far);
    end

    initial
    begin
        int unsigned hold;
        @(posedge rst_n);
        forever
        begin
            hold = quiet ? 0 : $urandom_range(0, 5);
            repeat (hold)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
            @(negedge clk);
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    function automatic value_t rnd48();
        return value_t'({$urandom(), $urandom()});
    endfunction

    function automatic value_t pick_value();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return value_t'($urandom_range(0, 1000));
            3: return '1 - value_t'($urandom_range(0, 1000));
            default: return rnd48();
        endcase
    endfunction

    function automatic value_t pick_span();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return value_t'($urandom_range(1, 64));
            3: return value_t'($urandom_range(1, 100000));
            4: return rnd48() >> $urandom_range(0, 40);
            default: return rnd48();
        endcase
    endfunction

    function automatic int prefix_len(int st);
        int n;
        n = 0;
        while (n < DEF_ENTRIES && slot_written[st][n])
            n++;
        return n;
    endfunction

    task automatic issue(cmd_t cmd, logic [2:0] stage, logic [5:0] slot, value_t d,
                         value_t s, value_t l, logic [6:0] used, value_t q);
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(0, 5);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        command <= cmd;
        stage_number <= stage;
        entry_slot <= slot;
        dest_start <= d;
        source_start <= s;
        span_length <= l;
        used_entries <= used;
        query_value <= q;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        tracker.note_transaction(cmd, stage, slot, d, s, l, used, q);
        if (cmd == CMD_WRITE && stage < DEF_STAGES)
            slot_written[stage][slot] = 1'b1;
        if (cmd == CMD_CLEAR)
            clears++;
        if (!((cmd == CMD_WRITE || cmd == CMD_COUNT) && stage >= DEF_STAGES))
            effective++;
    endtask

    task automatic write_entry(logic [2:0] stage, logic [5:0] slot, value_t d, value_t s,
                               value_t l);
        issue(CMD_WRITE, stage, slot, d, s, l, 7'($urandom), rnd48());
        if (stage < DEF_STAGES)
        begin
            probe_points.push_back(s);
            probe_points.push_back(s - 1);
            probe_points.push_back(s + l - 1);
            probe_points.push_back(s + l);
            while (probe_points.size() > 256)
                void'(probe_points.pop_front());
        end
    endtask

    task automatic set_count(logic [2:0] stage, logic [6:0] used);
        issue(CMD_COUNT, stage, 6'($urandom), rnd48(), rnd48(), rnd48(), used, rnd48());
    endtask

    task automatic map_value(value_t q);
        issue(CMD_MAP, 3'($urandom), 6'($urandom), rnd48(), rnd48(), rnd48(),
              7'($urandom), q);
    endtask

    task automatic clear_min();
        issue(CMD_CLEAR, 3'($urandom), 6'($urandom), rnd48(), rnd48(), rnd48(),
              7'($urandom), rnd48());
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.expected_maps.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int st;
        int fill;
        int pre;
        int burst;
        int base;
        bit first;
        logic [6:0] used;
        value_t q;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty tables pass values through, minimum tracking and clear
        map_value('1);
        map_value('0);
        clear_min();
        map_value(48'd12345);

        // stage 0: wrapping entry, overlapped entry, zero length, top-of-range entry
        write_entry(3'd0, 6'd0, '1 - 4, 48'd100, 48'd10);
        write_entry(3'd0, 6'd1, 48'd5000, 48'd100, 48'd50);
        write_entry(3'd0, 6'd2, 48'd12345, 48'd200, '0);
        write_entry(3'd0, 6'd3, 48'd7, '1 - 9, '1);
        set_count(3'd0, 7'd4);
        map_value(48'd100);
        map_value(48'd109);
        map_value(48'd110);
        map_value(48'd150);
        map_value(48'd99);
        map_value(48'd200);
        map_value('1);

        // stage out of range is ignored; last slot of last stage
        write_entry(3'd7, 6'd5, '0, '0, '1);
        set_count(3'd7, 7'd127);
        write_entry(3'd6, 6'd63, '1, '1, '1);
        clear_min();
        map_value(48'd5);

        drain();

        base = effective;
        first = 1'b1;
        while (effective < base + RANDOM_ITEMS)
        begin
            quiet = ($urandom_range(0, 5) == 0);
            st = $urandom_range(0, DEF_STAGES - 1);
            fill = (first || $urandom_range(0, 11) == 0) ? DEF_ENTRIES : $urandom_range(1, 6);
            first = 1'b0;
            for (int i = 0; i < fill; i++)
                write_entry(3'(st), 6'(i), pick_value(), pick_value(), pick_span());
            pre = prefix_len(st);
            if (pre == DEF_ENTRIES)
                full_loads++;
            if (pre == DEF_ENTRIES && $urandom_range(0, 1))
                used = 7'($urandom_range(DEF_ENTRIES, 127));
            else if ($urandom_range(0, 3) != 0)
                used = 7'(pre);
            else
                used = 7'($urandom_range(0, pre));
            set_count(3'(st), used);

            burst = $urandom_range(2, 8);
            for (int i = 0; i < burst; i++)
            begin
                case ($urandom_range(0, 9))
                    0: clear_min();
                    1: write_entry(3'($urandom_range(0, DEF_STAGES - 1)), 6'($urandom),
                                   pick_value(), pick_value(), pick_span());
                    2:
                    begin
                        if ($urandom_range(0, 1))
                            write_entry(3'd7, 6'($urandom), rnd48(), rnd48(), rnd48());
                        else
                            set_count(3'd7, 7'($urandom));
                    end
                    3:
                    begin
                        st = $urandom_range(0, DEF_STAGES - 1);
                        set_count(3'(st), 7'($urandom_range(0, prefix_len(st))));
                    end
                    default:
                    begin
                        if (probe_points.size() != 0 && $urandom_range(0, 2) != 0)
                            q = probe_points[$urandom_range(0, probe_points.size() - 1)];
                        else
                            q = pick_value();
                        map_value(q);
                    end
                endcase
            end

            if ($urandom_range(0, 15) == 0)
                drain();
        end

        @(negedge clk);
        in_valid <= 1'b0;
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("summary: %0d transactions accepted, %0d map results checked",
                 effective, tracker.checked);
        $display("summary: %0d clears, %0d full-table loads, %0d mismatches",
                 clears, full_loads, tracker.failures);
        if (tracker.failures == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

### sim.f
rtl/smr_pkg.sv
rtl/smr_table.sv
rtl/smr_scan.sv
rtl/staged_interval_remap_min_top.sv
tb/testbench.sv
